// ===== rtl/i2cw_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cw_pkg
// Shared types and constants for the I2C write phase sequencer.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [6:0] ADDR_RESET   = 7'h3C;
    localparam logic [3:0] BIT_ACK      = 4'd8;
    localparam int         QUEUE_DEPTH  = 2;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_START,
        SEG_ADDR,
        SEG_CTRL,
        SEG_DATA,
        SEG_STOP
    } t_seg;

    typedef struct packed {
        logic [7:0] addr_byte;
        logic [7:0] ctrl_byte;
        logic [7:0] data_byte;
        logic       open_transfer;
        logic       close_transfer;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/i2cw_if.sv =====
// ----------------------------------------------------------------------------
// i2cw_if
// Valid/ready channels: input items, bus phases and the address register.
// ----------------------------------------------------------------------------
interface i2cw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_data;
    logic       open_transfer;
    logic       close_transfer;

    modport source (output valid, data_byte, is_data, open_transfer, close_transfer,
                    input ready);
    modport sink   (input valid, data_byte, is_data, open_transfer, close_transfer,
                    output ready);
endinterface

interface i2cw_out_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic last_phase;

    modport source (output valid, scl_level, sda_level, last_phase, input ready);
    modport sink   (input valid, scl_level, sda_level, last_phase, output ready);
endinterface

interface i2cw_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] device_address;

    modport source (output valid, device_address, input ready);
    modport sink   (input valid, device_address, output ready);
endinterface

// ===== rtl/i2cw_front.sv =====
// ----------------------------------------------------------------------------
// i2cw_front
// Holds the device address and turns each input transaction into a
// descriptor with the address, control and payload bytes.
// ----------------------------------------------------------------------------
module i2cw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    i2cw_in_if.sink              i_in,
    i2cw_cfg_if.sink             i_cfg,
    input  i2cw_pkg::t_q_status  i_stat,
    output logic                 o_push,
    output i2cw_pkg::t_desc      o_desc
);

    logic [6:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= i2cw_pkg::ADDR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_addr <= i_cfg.device_address;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_stat.full;
    assign o_push      = i_in.valid && !i_stat.full;

    always_comb begin
        o_desc.addr_byte      = {r_addr, 1'b0};
        o_desc.ctrl_byte      = i_in.is_data ? i2cw_pkg::CTRL_DATA : i2cw_pkg::CTRL_COMMAND;
        o_desc.data_byte      = i_in.data_byte;
        o_desc.open_transfer  = i_in.open_transfer;
        o_desc.close_transfer = i_in.close_transfer;
    end

endmodule

// ===== rtl/i2cw_queue.sv =====
// ----------------------------------------------------------------------------
// i2cw_queue
// Small descriptor FIFO between the front end and the phase sequencer.
// ----------------------------------------------------------------------------
module i2cw_queue #(
    parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2cw_pkg::t_desc      i_desc,
    input  logic                 i_pop,
    output i2cw_pkg::t_desc      o_desc,
    output i2cw_pkg::t_q_status  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cw_pkg::t_desc r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_desc       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/i2cw_back.sv =====
// ----------------------------------------------------------------------------
// i2cw_back
// Phase sequencer: walks start, address, control, payload and stop
// segments, one bus phase per cycle while not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module i2cw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cw_pkg::t_desc      i_desc,
    input  i2cw_pkg::t_q_status  i_stat,
    output logic                 o_pop,
    i2cw_out_if.source           o_out
);

    i2cw_pkg::t_seg  r_seg, n_seg;
    logic [3:0]      r_bit, n_bit;
    logic            r_half, n_half;
    i2cw_pkg::t_desc r_desc, n_desc;

    logic r_out_valid;
    logic r_scl;
    logic r_sda;
    logic r_last;

    logic       w_advance;
    logic       w_is_ack;
    logic [7:0] w_byte;
    logic       w_scl;
    logic       w_sda;
    logic       w_item_end;

    assign w_advance = !r_out_valid || o_out.ready;
    assign w_is_ack  = (r_bit == i2cw_pkg::BIT_ACK);

    // phase levels for the current state
    always_comb begin
        w_byte     = r_desc.data_byte;
        w_scl      = 1'b1;
        w_sda      = 1'b1;
        w_item_end = 1'b0;
        case (r_seg)
            i2cw_pkg::SEG_START: begin
                w_sda = !r_half;
            end
            i2cw_pkg::SEG_ADDR, i2cw_pkg::SEG_CTRL, i2cw_pkg::SEG_DATA: begin
                if (r_seg == i2cw_pkg::SEG_ADDR) begin
                    w_byte = r_desc.addr_byte;
                end else if (r_seg == i2cw_pkg::SEG_CTRL) begin
                    w_byte = r_desc.ctrl_byte;
                end
                w_scl = r_half;
                w_sda = w_is_ack ? 1'b1 : w_byte[3'd7 - r_bit[2:0]];
                w_item_end = (r_seg == i2cw_pkg::SEG_DATA) && w_is_ack && r_half
                             && !r_desc.close_transfer;
            end
            i2cw_pkg::SEG_STOP: begin
                w_sda      = r_half;
                w_item_end = r_half;
            end
            default: begin
                w_scl = 1'b1;
                w_sda = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        logic w_load;
        w_load = 1'b0;
        n_seg  = r_seg;
        n_bit  = r_bit;
        n_half = r_half;
        n_desc = r_desc;
        if (w_advance) begin
            if (r_seg == i2cw_pkg::SEG_IDLE) begin
                w_load = !i_stat.empty;
            end else if (w_item_end) begin
                w_load = !i_stat.empty;
                n_seg  = i2cw_pkg::SEG_IDLE;
            end else if (!r_half) begin
                n_half = 1'b1;
            end else begin
                n_half = 1'b0;
                case (r_seg)
                    i2cw_pkg::SEG_START: begin
                        n_seg = i2cw_pkg::SEG_ADDR;
                        n_bit = '0;
                    end
                    i2cw_pkg::SEG_ADDR, i2cw_pkg::SEG_CTRL, i2cw_pkg::SEG_DATA: begin
                        if (!w_is_ack) begin
                            n_bit = r_bit + 1'b1;
                        end else begin
                            n_bit = '0;
                            if (r_seg == i2cw_pkg::SEG_ADDR) begin
                                n_seg = i2cw_pkg::SEG_CTRL;
                            end else if (r_seg == i2cw_pkg::SEG_CTRL) begin
                                n_seg = i2cw_pkg::SEG_DATA;
                            end else begin
                                n_seg = i2cw_pkg::SEG_STOP;
                            end
                        end
                    end
                    default: begin
                        n_seg = i2cw_pkg::SEG_IDLE;
                    end
                endcase
            end
        end
        if (w_load) begin
            n_desc = i_desc;
            n_seg  = i_desc.open_transfer ? i2cw_pkg::SEG_START : i2cw_pkg::SEG_DATA;
            n_bit  = '0;
            n_half = 1'b0;
        end
        o_pop = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= i2cw_pkg::SEG_IDLE;
            r_bit       <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seg  <= n_seg;
            r_bit  <= n_bit;
            r_half <= n_half;
            if (w_advance) begin
                r_out_valid <= (r_seg != i2cw_pkg::SEG_IDLE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        if (w_advance) begin
            r_scl  <= w_scl;
            r_sda  <= w_sda;
            r_last <= w_item_end;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scl_level  = r_scl;
    assign o_out.sda_level  = r_sda;
    assign o_out.last_phase = r_last;

endmodule

// ===== rtl/i2c_write_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_write_phase_sequencer
// Write-only I2C master framer: expands bytes into SCL/SDA bus phases.
// ----------------------------------------------------------------------------
// Channels: i_in takes one transaction per item (payload byte, command/data
// flag, open and close marks). o_out gives one bus phase per transaction
// (scl_level, sda_level, last_phase on the final phase of an item).
// i_cfg writes the 7-bit device address; always ready, write only while idle.
// Phases per item: 18 for a plain byte, +38 with open (start, address,
// control byte), +2 with close (stop). The phase sequencer emits one phase per
// cycle while o_out is not stalled; consecutive items follow with no gap when
// the next one is already queued. From an idle block the first phase passes
// through the queue, the segment state register and then the output register.
// Input items wait in a small descriptor queue (QUEUE_DEPTH entries); i_in
// ready drops only when it is full.
// Reset: address returns to 0x3C, queue empties, output valid drops.
// When o_out stalls, the phase holds and the sequencer waits; the queue
// still takes input until it fills.
// ----------------------------------------------------------------------------
module i2c_write_phase_sequencer #(
    parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cw_in_if.sink     i_in,
    i2cw_cfg_if.sink    i_cfg,
    i2cw_out_if.source  o_out
);

    logic                w_push;
    logic                w_pop;
    i2cw_pkg::t_desc     w_push_desc;
    i2cw_pkg::t_desc     w_head_desc;
    i2cw_pkg::t_q_status w_q_stat;

    i2cw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_stat  (w_q_stat),
        .o_push  (w_push),
        .o_desc  (w_push_desc)
    );

    i2cw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_desc  (w_head_desc),
        .o_stat  (w_q_stat)
    );

    i2cw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (w_head_desc),
        .i_stat  (w_q_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_stat.empty)
        else $error("accepted transaction missing from queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

endmodule
